[sv/ohlcv_bar_aggregator_defines.svh]
// Assertion macros for the OHLCV bar aggregator checker.
// No dependencies; included by the files that assert.
`ifndef OHLCV_BAR_AGGREGATOR_DEFINES_SVH
`define OHLCV_BAR_AGGREGATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define OBAGG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obagg: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define OBAGG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obagg: next-cycle check failed");

`endif

[sv/obagg_pkg.sv]
// Shared types and constants for the OHLCV bar aggregator.
// No dependencies; used by every module and by the checker.
package obagg_pkg;

    localparam int unsigned PRICE_W  = 32;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned VOL_IN_W = 32;
    localparam int unsigned VOL_W    = 48;
    localparam int unsigned PERIOD_W = 20;

    // One remainder bit is resolved per step of the divider
    localparam int unsigned DIV_STEPS = TIME_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(60);
    localparam logic [VOL_W-1:0]    VOL_MAX      = '1;

    typedef logic [PERIOD_W-1:0] t_period;

    typedef struct packed {
        logic [TIME_W-1:0]   tick_seconds;
        logic [PRICE_W-1:0]  tick_high;
        logic [PRICE_W-1:0]  tick_low;
        logic [PRICE_W-1:0]  tick_close;
        logic [VOL_IN_W-1:0] tick_volume;
    } t_tick;

    typedef struct packed {
        logic               bar_done;
        logic [TIME_W-1:0]  bar_time;
        logic [PRICE_W-1:0] bar_open;
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
        logic [PRICE_W-1:0] bar_close;
        logic [VOL_W-1:0]   bar_volume;
    } t_bar;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic div_step;
        logic make_start;
        logic update;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_stall;
    } t_sts;

endpackage

[sv/obagg_stream_if.sv]
// Valid/ready channel carrying one payload per beat.
// No dependencies; the payload type is set per instance.
interface obagg_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/obagg_ctrl.sv]
// Sequencer for the bar aggregator: accept, remainder steps, start, update.
// Depends on obagg_pkg.
module obagg_ctrl
    import obagg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_tick_valid,
    output logic o_tick_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DIV    = 4'b0010,
        S_START  = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              w_last_step;

    assign w_last_step  = (r_cnt == STEP_W'(DIV_STEPS - 1));
    assign o_tick_ready = (r_state == S_IDLE);

    // Decode commands from the current state
    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = (r_state == S_IDLE) && i_tick_valid;
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.make_start = (r_state == S_START);
        o_cmd.update     = (r_state == S_UPDATE) && !i_sts.out_stall;
    end

    // Next state: hold in update while the output register is still full
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_tick_valid) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + STEP_W'(1);
                if (w_last_step) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!i_sts.out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[sv/obagg_dp.sv]
// Datapath: period register, bit-serial remainder, bar state and output register.
// Depends on obagg_pkg.
module obagg_dp
    import obagg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_tick   i_tick,
    input  logic    i_cfg_valid,
    input  t_period i_cfg_data,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    output logic    o_bar_valid,
    input  logic    i_bar_ready,
    output t_bar    o_bar
);

    t_period             r_period;
    t_period             w_divisor;
    t_tick               r_tick;
    logic [TIME_W-1:0]   r_dividend;
    t_period             r_rem;
    logic [PERIOD_W:0]   w_shift;
    logic [PERIOD_W:0]   w_diff;
    logic                w_ge;
    logic [TIME_W-1:0]   r_start;

    logic                r_open;
    logic [TIME_W-1:0]   r_cur_start;
    logic [PRICE_W-1:0]  r_cur_open;
    logic [PRICE_W-1:0]  r_cur_high;
    logic [PRICE_W-1:0]  r_cur_low;
    logic [PRICE_W-1:0]  r_cur_close;
    logic [VOL_W-1:0]    r_cur_vol;

    logic                w_new_bar;
    logic                w_fresh;
    logic [VOL_W:0]      w_vol_sum;
    logic [VOL_W-1:0]    w_vol_merged;
    logic [PRICE_W-1:0]  w_high_merged;
    logic [PRICE_W-1:0]  w_low_merged;
    t_bar                w_result;

    logic                r_out_valid;
    t_bar                r_out;

    // Hold the period; a zero period counts as one second
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_data;
        end
    end

    assign w_divisor = (r_period == '0) ? PERIOD_W'(1) : r_period;

    // One restoring remainder step: shift in the next time bit, subtract if it fits
    assign w_shift = {r_rem, r_dividend[TIME_W-1]};
    assign w_ge    = (w_shift >= {1'b0, w_divisor});
    assign w_diff  = w_shift - {1'b0, w_divisor};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tick     <= i_tick;
            r_dividend <= i_tick.tick_seconds;
            r_rem      <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= r_dividend << 1;
            r_rem      <= w_ge ? w_diff[PERIOD_W-1:0] : w_shift[PERIOD_W-1:0];
        end
        if (i_cmd.make_start) begin
            r_start <= r_tick.tick_seconds - TIME_W'(r_rem);
        end
    end

    // Merge candidates for a tick that stays in the current bar
    assign w_new_bar     = r_open && (r_start > r_cur_start);
    assign w_fresh       = !r_open || w_new_bar;
    assign w_vol_sum     = {1'b0, r_cur_vol} + (VOL_W + 1)'(r_tick.tick_volume);
    assign w_vol_merged  = w_vol_sum[VOL_W] ? VOL_MAX : w_vol_sum[VOL_W-1:0];
    assign w_high_merged = (r_tick.tick_high > r_cur_high) ? r_tick.tick_high : r_cur_high;
    assign w_low_merged  = (r_tick.tick_low < r_cur_low) ? r_tick.tick_low : r_cur_low;

    // Pick the beat to emit: finished bar, freshly opened bar or running bar
    always_comb begin
        if (w_new_bar) begin
            w_result = '{bar_done: 1'b1, bar_time: r_cur_start, bar_open: r_cur_open,
                         bar_high: r_cur_high, bar_low: r_cur_low,
                         bar_close: r_cur_close, bar_volume: r_cur_vol};
        end else if (w_fresh) begin
            w_result = '{bar_done: 1'b0, bar_time: r_start, bar_open: r_tick.tick_close,
                         bar_high: r_tick.tick_high, bar_low: r_tick.tick_low,
                         bar_close: r_tick.tick_close,
                         bar_volume: VOL_W'(r_tick.tick_volume)};
        end else begin
            w_result = '{bar_done: 1'b0, bar_time: r_cur_start, bar_open: r_cur_open,
                         bar_high: w_high_merged, bar_low: w_low_merged,
                         bar_close: r_tick.tick_close, bar_volume: w_vol_merged};
        end
    end

    // Open flag is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (i_cmd.update) begin
            r_open <= 1'b1;
        end
    end

    // Advance the current bar
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (w_fresh) begin
                r_cur_start <= r_start;
                r_cur_open  <= r_tick.tick_close;
                r_cur_high  <= r_tick.tick_high;
                r_cur_low   <= r_tick.tick_low;
                r_cur_close <= r_tick.tick_close;
                r_cur_vol   <= VOL_W'(r_tick.tick_volume);
            end else begin
                r_cur_high  <= w_high_merged;
                r_cur_low   <= w_low_merged;
                r_cur_close <= r_tick.tick_close;
                r_cur_vol   <= w_vol_merged;
            end
        end
    end

    // Output register: load on update, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_bar_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out <= w_result;
        end
    end

    assign o_sts.out_stall = r_out_valid && !i_bar_ready;
    assign o_bar_valid     = r_out_valid;
    assign o_bar           = r_out;

endmodule

[sv/ohlcv_bar_aggregator.sv]
// Top level of the OHLCV bar aggregator: controller plus datapath.
// Depends on obagg_pkg, obagg_stream_if, obagg_ctrl and obagg_dp.
//
//   Port     Dir   Payload             Beat
//   i_tick   in    t_tick (5 fields)   one market tick
//   o_bar    out   t_bar (7 fields)    one bar result per tick
//   i_cfg    in    t_period (20 bits)  bar_period write, always ready
//
// A tick is accepted, then the bit-serial remainder of the time by the period is
// resolved (one bit per cycle), then the bar start is formed, and then the bar is
// updated and the output register loaded. The next tick is taken the cycle after
// that. The update waits while the previous result is still unread. Reset
// (synchronous, active low) empties the output and closes the bar.
module ohlcv_bar_aggregator
    import obagg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    obagg_stream_if.sink          i_tick,
    obagg_stream_if.source        o_bar,
    obagg_stream_if.sink          i_cfg
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign i_cfg.ready = 1'b1;

    obagg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (i_tick.valid),
        .o_tick_ready (i_tick.ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    obagg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (i_tick.payload),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.payload),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_bar_valid (o_bar.valid),
        .i_bar_ready (o_bar.ready),
        .o_bar       (o_bar.payload)
    );

endmodule

[sv/obagg_checker.sv]
// Port-level checks for the bar aggregator, bound to the top level.
// Depends on obagg_pkg and ohlcv_bar_aggregator_defines.svh.
`include "ohlcv_bar_aggregator_defines.svh"

module obagg_checker
    import obagg_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_tick_valid,
    input logic i_tick_ready,
    input logic i_bar_valid,
    input logic i_bar_ready,
    input t_bar i_bar
);

    // A result waiting to be taken stays offered
    `OBAGG_ASSERT_NEXT(a_bar_valid_hold, i_clk, i_rst_n, i_bar_valid && !i_bar_ready, i_bar_valid)

    // A stalled result keeps its payload
    `OBAGG_ASSERT_NEXT(a_bar_payload_hold, i_clk, i_rst_n, i_bar_valid && !i_bar_ready, $stable(i_bar))

    // One tick at a time: input closes right after a tick beat
    `OBAGG_ASSERT_NEXT(a_tick_single, i_clk, i_rst_n, i_tick_valid && i_tick_ready, !i_tick_ready)

    // A new result appears only after tick work, with the tick input closed
    `OBAGG_ASSERT_NOW(a_bar_after_work, i_clk, i_rst_n, $rose(i_bar_valid), $past(!i_tick_ready))

endmodule

bind ohlcv_bar_aggregator obagg_checker u_obagg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_tick_valid (i_tick.valid),
    .i_tick_ready (i_tick.ready),
    .i_bar_valid  (o_bar.valid),
    .i_bar_ready  (o_bar.ready),
    .i_bar        (o_bar.payload)
);

[dv/ohlcv_bar_aggregator_tb.sv]
// Self-checking testbench for ohlcv_bar_aggregator: a directed table, then random ticks.
// Depends on obagg_pkg, obagg_stream_if and the RTL of ohlcv_bar_aggregator.
// A bar predictor built into the bench checks every result beat.
module ohlcv_bar_aggregator_tb;
    import obagg_pkg::*;

    localparam int unsigned STALL_LIMIT     = 5000;
    localparam int unsigned DRAIN_CYCLES    = 80;
    localparam int unsigned PRESSURE_CYCLES = 400;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned RAND_PHASES     = 6;
    localparam int unsigned TICKS_PER_PHASE = 150;
    localparam logic [31:0] ALL_ONES        = '1;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_period   period;
        t_tick     tick;
        logic      typed;
        t_bar      bar;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;

    obagg_stream_if #(.t_payload(t_tick))   tick_if ();
    obagg_stream_if #(.t_payload(t_bar))    bar_if ();
    obagg_stream_if #(.t_payload(t_period)) cfg_if ();

    ohlcv_bar_aggregator u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_if),
        .o_bar   (bar_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    wire tick_acc = tick_if.valid && tick_if.ready;
    wire bar_acc  = bar_if.valid && bar_if.ready;
    wire cfg_acc  = cfg_if.valid && cfg_if.ready;

    // Predictor state: the bar being built and the period in force
    t_period     period_q   = PERIOD_RESET;
    logic        bar_live   = 1'b0;
    logic [31:0] cur_start  = '0;
    logic [31:0] cur_open   = '0;
    logic [31:0] cur_high   = '0;
    logic [31:0] cur_low    = '0;
    logic [31:0] cur_close  = '0;
    logic [47:0] cur_vol    = '0;

    t_bar        expected_bars[$];
    t_stim_row   directed_rows[$];
    int unsigned outstanding  = 0;
    int unsigned fail_count   = 0;
    int unsigned bar_count    = 0;
    int unsigned stall_cycles = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        hold_req;
    logic        row_typed;
    t_bar        row_bar;

    // Fold one tick into the bar and return the bar that this tick reports
    function automatic t_bar fold_tick(input t_tick tk);
        logic [31:0] span;
        logic [31:0] start;
        logic [48:0] vol_sum;
        logic        closing;
        t_bar        res;
        span    = (period_q == '0) ? 32'd1 : 32'(period_q);
        start   = tk.tick_seconds - (tk.tick_seconds % span);
        closing = bar_live && (start > cur_start);
        res     = {1'b1, cur_start, cur_open, cur_high, cur_low, cur_close, cur_vol};
        if (!bar_live || closing) begin
            bar_live  = 1'b1;
            cur_start = start;
            cur_open  = tk.tick_close;
            cur_high  = tk.tick_high;
            cur_low   = tk.tick_low;
            cur_close = tk.tick_close;
            cur_vol   = 48'(tk.tick_volume);
        end else begin
            if (tk.tick_high > cur_high) cur_high = tk.tick_high;
            if (tk.tick_low < cur_low) cur_low = tk.tick_low;
            cur_close = tk.tick_close;
            vol_sum   = 49'(cur_vol) + 49'(tk.tick_volume);
            cur_vol   = vol_sum[48] ? VOL_MAX : vol_sum[47:0];
        end
        if (!closing) begin
            res = {1'b0, cur_start, cur_open, cur_high, cur_low, cur_close, cur_vol};
        end
        return res;
    endfunction

    function automatic void add_row(input t_row_kind kind, input t_period p, input t_tick tk,
                                    input logic typed, input t_bar b);
        t_stim_row row;
        row.kind   = kind;
        row.period = p;
        row.tick   = tk;
        row.typed  = typed;
        row.bar    = b;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("bar beat %0d: %s expected %h got %h", bar_count, name, want, got);
            end
        end
    endtask

    // Predict on each accepted tick, compare each accepted bar with the oldest prediction
    always @(posedge clk) begin : bar_monitor
        t_bar want;
        t_bar got;
        if (rst_n) begin
            if (cfg_acc) period_q = cfg_if.payload;
            if (tick_acc) begin
                want = fold_tick(tick_if.payload);
                expected_bars.insert(expected_bars.size(), row_typed ? row_bar : want);
            end
            if (bar_acc) begin
                got = bar_if.payload;
                if (expected_bars.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("bar beat %0d: no bar expected, got %h", bar_count, got);
                    end
                end else begin
                    want = expected_bars.pop_front();
                    check_field("bar_done", 64'(want.bar_done), 64'(got.bar_done));
                    check_field("bar_time", 64'(want.bar_time), 64'(got.bar_time));
                    check_field("bar_open", 64'(want.bar_open), 64'(got.bar_open));
                    check_field("bar_high", 64'(want.bar_high), 64'(got.bar_high));
                    check_field("bar_low", 64'(want.bar_low), 64'(got.bar_low));
                    check_field("bar_close", 64'(want.bar_close), 64'(got.bar_close));
                    check_field("bar_volume", 64'(want.bar_volume), 64'(got.bar_volume));
                end
                bar_count++;
            end
            outstanding <= outstanding + int'(tick_acc) - int'(bar_acc);
        end
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || tick_acc || bar_acc || cfg_acc) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Bar receiver: random back-pressure, plus one long hold-off on request
    initial begin : bar_receiver
        logic hold_served;
        hold_served = 1'b0;
        bar_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                bar_if.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
            end else begin
                bar_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one tick beat, with random gaps in front, and hold it until taken
    task automatic send_tick(input t_tick tk, input logic typed, input t_bar b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(posedge clk);
        end
        tick_if.valid   <= 1'b1;
        tick_if.payload <= tk;
        row_typed       <= typed;
        row_bar         <= b;
        do @(posedge clk); while (!tick_if.ready);
    endtask

    // Write the period once every bar in flight has been read
    task automatic write_period(input t_period p);
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= p;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_period     phase_period [RAND_PHASES];
        logic [31:0] cursor;
        logic [31:0] t;
        int unsigned span;
        int unsigned r;
        rst_n           <= 1'b0;
        tick_if.valid   <= 1'b0;
        tick_if.payload <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.payload  <= '0;
        row_typed       <= 1'b0;
        row_bar         <= '0;
        hold_req        <= 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 75;

        // Directed table: reset period first, then the special cases
        // first tick opens a bar from extreme prices
        add_row(ROW_TICK, '0, {32'd0, ALL_ONES, 32'd0, ALL_ONES, ALL_ONES}, 1'b1,
                {1'b0, 32'd0, ALL_ONES, ALL_ONES, 32'd0, ALL_ONES, 48'h0000_FFFF_FFFF});
        // same bar, opposite extremes: high and low hold, close and volume move
        add_row(ROW_TICK, '0, {32'd59, 32'd0, ALL_ONES, 32'd0, ALL_ONES}, 1'b1,
                {1'b0, 32'd0, ALL_ONES, ALL_ONES, 32'd0, 32'd0, 48'h0001_FFFF_FFFE});
        // next period closes the bar
        add_row(ROW_TICK, '0, {32'd60, 32'd100, 32'd50, 32'd70, 32'd5}, 1'b1,
                {1'b1, 32'd0, ALL_ONES, ALL_ONES, 32'd0, 32'd0, 48'h0001_FFFF_FFFE});
        // late tick merges into the open bar
        add_row(ROW_TICK, '0, {32'd30, 32'd200, 32'd40, 32'd80, 32'd0}, 1'b0, '0);
        add_row(ROW_TICK, '0, {32'd119, 32'd100, 32'd60, 32'd90, 32'd0}, 1'b0, '0);
        // zero period acts as one second
        add_row(ROW_CFG, 20'd0, '0, 1'b0, '0);
        add_row(ROW_TICK, '0, {32'd121, 32'd300, 32'd20, 32'd150, 32'd9}, 1'b0, '0);
        // low above high is merged field by field
        add_row(ROW_TICK, '0, {32'd122, 32'd10, 32'd90000, 32'd50, 32'd7}, 1'b0, '0);
        add_row(ROW_TICK, '0, {32'd122, 32'd5, 32'd95000, 32'd6, 32'd1}, 1'b0, '0);
        // the largest period that fits the register is used as it stands
        add_row(ROW_CFG, 20'hFFFFF, '0, 1'b0, '0);
        add_row(ROW_TICK, '0, {32'd2097155, 32'd400, 32'd300, 32'd350, 32'd11}, 1'b0, '0);
        // period change with a bar open: the stored start stays, this tick is late
        add_row(ROW_CFG, 20'd604800, '0, 1'b0, '0);
        add_row(ROW_TICK, '0, {32'd2097160, 32'd500, 32'd250, 32'd260, 32'd13}, 1'b0, '0);
        add_row(ROW_CFG, 20'd1, '0, 1'b0, '0);
        add_row(ROW_TICK, '0, {32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678,
                               32'h8000_0000}, 1'b0, '0);
        add_row(ROW_TICK, '0, {32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8765_4321,
                               32'h7FFF_FFFF}, 1'b0, '0);

        phase_period[0] = 20'd1;
        phase_period[1] = 20'd604800;
        phase_period[2] = t_period'($urandom_range(2, 3600));
        phase_period[3] = 20'hFFFFF;
        phase_period[4] = 20'd0;
        phase_period[5] = t_period'($urandom_range(1, 604800));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_period(directed_rows[i].period);
            end else begin
                send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].bar);
            end
        end

        // Random phases: mostly forward time with some late and stray ticks
        cursor = 32'h8000_0000 + $urandom_range(0, 1000);
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 75 : 0;
            recv_idle_pct = (ph < 2) ? 75 : (ph < 4) ? 10 : 0;
            write_period(phase_period[ph]);
            if (ph == 4) hold_req <= 1'b1;
            span = (phase_period[ph] == '0) ? 1 : int'(phase_period[ph]);
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    cursor = cursor + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 3 * span)
                                                                    : $urandom_range(0, span / 4));
                    t = cursor;
                end else if (r < 94) begin
                    t = cursor - $urandom_range(0, 2 * span);
                end else begin
                    t = $urandom_range(0, cursor);
                end
                send_tick({t, 32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)},
                          1'b0, '0);
            end
        end

        // Latest possible time to finish
        send_tick({ALL_ONES, 32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)},
                  1'b0, '0);
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_bars.size() != 0) begin
            $display("%0d expected bars never arrived", expected_bars.size());
        end
        if (fail_count == 0 && expected_bars.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[ohlcv_bar_aggregator.f]
+incdir+sv
sv/obagg_pkg.sv
sv/obagg_stream_if.sv
sv/obagg_ctrl.sv
sv/obagg_dp.sv
sv/ohlcv_bar_aggregator.sv
sv/obagg_checker.sv
dv/ohlcv_bar_aggregator_tb.sv
